FILE: rtl/rcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_pkg: shared constants and types for the crop/rotate color front end
// Frame geometry, counter widths, accumulator steps and color expansion
// constants used by the position tracker, the color unit and the top level.
// ----------------------------------------------------------------------------
package rcr_pkg;

  // Frame geometry
  localparam int SRC_WIDTH  = 320;
  localparam int SRC_HEIGHT = 240;
  localparam int OUT_WIDTH  = 224;
  localparam int OUT_HEIGHT = 224;

  // Left edge of the centered square crop (zero for a tall source)
  localparam int CROP_ORIGIN = (SRC_WIDTH >= SRC_HEIGHT) ? (SRC_WIDTH - SRC_HEIGHT) / 2 : 0;

  // Field widths
  localparam int PIX_W = 16;
  localparam int IDX_W = 16;
  localparam int CH_W  = 8;

  // Counter widths
  localparam int SCOL_W = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
  localparam int SROW_W = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
  localparam int OCOL_W = $clog2(OUT_WIDTH + 1);
  localparam int OROW_W = $clog2(OUT_HEIGHT + 1);
  localparam int CTGT_W = $clog2(CROP_ORIGIN + SRC_HEIGHT + 1);
  localparam int RTGT_W = $clog2(SRC_HEIGHT + 1);
  localparam int CREM_W = $clog2(2 * OUT_WIDTH);
  localparam int RREM_W = $clog2(2 * OUT_HEIGHT);
  localparam int CCMP_W = (CTGT_W > SCOL_W) ? CTGT_W : SCOL_W;
  localparam int RCMP_W = (RTGT_W > SROW_W) ? RTGT_W : SROW_W;

  // Target accumulator steps: target advances by H/W plus a carry from H%W
  localparam int COL_Q = SRC_HEIGHT / OUT_WIDTH;
  localparam int COL_R = SRC_HEIGHT % OUT_WIDTH;
  localparam int ROW_Q = SRC_HEIGHT / OUT_HEIGHT;
  localparam int ROW_R = SRC_HEIGHT % OUT_HEIGHT;

  // Row base of the first output pixel (bottom row after the half turn)
  localparam int ROW_BASE_INIT = (OUT_HEIGHT - 1) * OUT_WIDTH;

  // Color expansion: v*255/31 = 8v + floor(7v/31), v*255/63 = 4v + floor(v/21)
  localparam int R5_MUL     = 7;
  localparam int R5_RECIP   = 265;  // ~ 2^13 / 31
  localparam int R5_SHIFT   = 13;
  localparam int G6_RECIP   = 49;   // ~ 2^10 / 21
  localparam int G6_SHIFT   = 10;

  // Luma weights
  localparam int LUMA_R = 77;
  localparam int LUMA_G = 150;
  localparam int LUMA_B = 29;
  localparam int LUMA_W = 17;

  // Decision for the item being accepted
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] index;
  } pos_sel_t;

endpackage

FILE: rtl/rcr_position.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_position: raster position tracker and pixel selector
// Follows the source raster, decides whether the incoming pixel is sampled
// and computes its rotated output index. State advances on each accepted item.
// ----------------------------------------------------------------------------
module rcr_position (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic                   frame_start_i,
  output rcr_pkg::pos_sel_t      sel_o
);

  localparam logic [rcr_pkg::CTGT_W-1:0] CtgtInit =
    rcr_pkg::CTGT_W'(rcr_pkg::CROP_ORIGIN);
  localparam logic [rcr_pkg::IDX_W-1:0] RowBaseInit =
    rcr_pkg::IDX_W'(rcr_pkg::ROW_BASE_INIT);

  logic [rcr_pkg::SCOL_W-1:0] scol_q, scol_d, scol_e;
  logic [rcr_pkg::SROW_W-1:0] srow_q, srow_d, srow_e;
  logic [rcr_pkg::OCOL_W-1:0] ocol_q, ocol_d, ocol_e;
  logic [rcr_pkg::OROW_W-1:0] orow_q, orow_d, orow_e;
  logic [rcr_pkg::CTGT_W-1:0] ctgt_q, ctgt_d, ctgt_e;
  logic [rcr_pkg::RTGT_W-1:0] rtgt_q, rtgt_d, rtgt_e;
  logic [rcr_pkg::CREM_W-1:0] crem_q, crem_d, crem_e, crem_sum;
  logic [rcr_pkg::RREM_W-1:0] rrem_q, rrem_d, rrem_e, rrem_sum;
  logic [rcr_pkg::IDX_W-1:0]  rbase_q, rbase_d, rbase_e;
  logic                       row_hit, pix_hit;

  // Effective state: a frame-start item sees the cleared position
  always_comb begin
    if (frame_start_i) begin
      scol_e  = '0;
      srow_e  = '0;
      ocol_e  = '0;
      orow_e  = '0;
      ctgt_e  = CtgtInit;
      rtgt_e  = '0;
      crem_e  = '0;
      rrem_e  = '0;
      rbase_e = RowBaseInit;
    end else begin
      scol_e  = scol_q;
      srow_e  = srow_q;
      ocol_e  = ocol_q;
      orow_e  = orow_q;
      ctgt_e  = ctgt_q;
      rtgt_e  = rtgt_q;
      crem_e  = crem_q;
      rrem_e  = rrem_q;
      rbase_e = rbase_q;
    end
  end

  // Sample decision and rotated index
  always_comb begin
    row_hit = (orow_e < rcr_pkg::OROW_W'(rcr_pkg::OUT_HEIGHT)) &&
              (rcr_pkg::RCMP_W'(srow_e) == rcr_pkg::RCMP_W'(rtgt_e));
    pix_hit = row_hit &&
              (ocol_e < rcr_pkg::OCOL_W'(rcr_pkg::OUT_WIDTH)) &&
              (rcr_pkg::CCMP_W'(scol_e) == rcr_pkg::CCMP_W'(ctgt_e));
    sel_o.hit   = pix_hit;
    sel_o.index = rbase_e + rcr_pkg::IDX_W'(rcr_pkg::OUT_WIDTH - 1)
                - rcr_pkg::IDX_W'(ocol_e);
  end

  // Next position: column/row targets advance by running quotient/remainder
  always_comb begin
    scol_d  = scol_e;
    srow_d  = srow_e;
    ocol_d  = ocol_e;
    orow_d  = orow_e;
    ctgt_d  = ctgt_e;
    rtgt_d  = rtgt_e;
    crem_d  = crem_e;
    rrem_d  = rrem_e;
    rbase_d = rbase_e;
    crem_sum = crem_e + rcr_pkg::CREM_W'(rcr_pkg::COL_R);
    rrem_sum = rrem_e + rcr_pkg::RREM_W'(rcr_pkg::ROW_R);

    if (pix_hit) begin
      ocol_d = ocol_e + 1'b1;
      if (crem_sum >= rcr_pkg::CREM_W'(rcr_pkg::OUT_WIDTH)) begin
        ctgt_d = ctgt_e + rcr_pkg::CTGT_W'(rcr_pkg::COL_Q + 1);
        crem_d = crem_sum - rcr_pkg::CREM_W'(rcr_pkg::OUT_WIDTH);
      end else begin
        ctgt_d = ctgt_e + rcr_pkg::CTGT_W'(rcr_pkg::COL_Q);
        crem_d = crem_sum;
      end
    end

    if (scol_e == rcr_pkg::SCOL_W'(rcr_pkg::SRC_WIDTH - 1)) begin
      scol_d = '0;
      ocol_d = '0;
      ctgt_d = CtgtInit;
      crem_d = '0;
      if (row_hit) begin
        orow_d  = orow_e + 1'b1;
        rbase_d = rbase_e - rcr_pkg::IDX_W'(rcr_pkg::OUT_WIDTH);
        if (rrem_sum >= rcr_pkg::RREM_W'(rcr_pkg::OUT_HEIGHT)) begin
          rtgt_d = rtgt_e + rcr_pkg::RTGT_W'(rcr_pkg::ROW_Q + 1);
          rrem_d = rrem_sum - rcr_pkg::RREM_W'(rcr_pkg::OUT_HEIGHT);
        end else begin
          rtgt_d = rtgt_e + rcr_pkg::RTGT_W'(rcr_pkg::ROW_Q);
          rrem_d = rrem_sum;
        end
      end
      // Last pixel of the frame wraps to a fresh frame
      if (srow_e == rcr_pkg::SROW_W'(rcr_pkg::SRC_HEIGHT - 1)) begin
        srow_d  = '0;
        orow_d  = '0;
        rtgt_d  = '0;
        rrem_d  = '0;
        rbase_d = RowBaseInit;
      end else begin
        srow_d = srow_e + 1'b1;
      end
    end else begin
      scol_d = scol_e + 1'b1;
    end
  end

  // Position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scol_q  <= '0;
      srow_q  <= '0;
      ocol_q  <= '0;
      orow_q  <= '0;
      ctgt_q  <= CtgtInit;
      rtgt_q  <= '0;
      crem_q  <= '0;
      rrem_q  <= '0;
      rbase_q <= RowBaseInit;
    end else if (accept_i) begin
      scol_q  <= scol_d;
      srow_q  <= srow_d;
      ocol_q  <= ocol_d;
      orow_q  <= orow_d;
      ctgt_q  <= ctgt_d;
      rtgt_q  <= rtgt_d;
      crem_q  <= crem_d;
      rrem_q  <= rrem_d;
      rbase_q <= rbase_d;
    end
  end

`ifndef SYNTHESIS
  a_scol_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scol_q <= rcr_pkg::SCOL_W'(rcr_pkg::SRC_WIDTH - 1))
    else $error("source column out of range");

  a_ocol_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocol_q <= rcr_pkg::OCOL_W'(rcr_pkg::OUT_WIDTH))
    else $error("output column out of range");

  a_crem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crem_q < rcr_pkg::CREM_W'(rcr_pkg::OUT_WIDTH))
    else $error("column remainder out of range");
`endif

endmodule

FILE: rtl/rcr_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_color: RGB565 to RGB888 expansion with luma
// Expands each channel to eight bits by reciprocal multiply and computes
// the weighted luma of the expanded pixel.
// ----------------------------------------------------------------------------
module rcr_color (
  input  logic [rcr_pkg::PIX_W-1:0] pixel_word_i,
  output logic [rcr_pkg::CH_W-1:0]  red_o,
  output logic [rcr_pkg::CH_W-1:0]  green_o,
  output logic [rcr_pkg::CH_W-1:0]  blue_o,
  output logic [rcr_pkg::CH_W-1:0]  luma_o
);

  logic [4:0]  r5, b5;
  logic [5:0]  g6;
  logic [7:0]  r7, b7;
  logic [16:0] r_prod, b_prod;
  logic [11:0] g_prod;
  logic [rcr_pkg::LUMA_W-1:0] luma_sum;

  always_comb begin
    r5 = pixel_word_i[15:11];
    g6 = pixel_word_i[10:5];
    b5 = pixel_word_i[4:0];

    // 5-bit channels: 8v + floor(7v/31)
    r7     = 8'(r5) * 8'(rcr_pkg::R5_MUL);
    b7     = 8'(b5) * 8'(rcr_pkg::R5_MUL);
    r_prod = 17'(r7) * 17'(rcr_pkg::R5_RECIP);
    b_prod = 17'(b7) * 17'(rcr_pkg::R5_RECIP);
    red_o  = {r5, 3'b000} + 8'(r_prod >> rcr_pkg::R5_SHIFT);
    blue_o = {b5, 3'b000} + 8'(b_prod >> rcr_pkg::R5_SHIFT);

    // 6-bit channel: 4v + floor(v/21)
    g_prod  = 12'(g6) * 12'(rcr_pkg::G6_RECIP);
    green_o = {g6, 2'b00} + 8'(g_prod >> rcr_pkg::G6_SHIFT);

    // Luma from the expanded channels
    luma_sum = rcr_pkg::LUMA_W'(red_o)   * rcr_pkg::LUMA_W'(rcr_pkg::LUMA_R)
             + rcr_pkg::LUMA_W'(green_o) * rcr_pkg::LUMA_W'(rcr_pkg::LUMA_G)
             + rcr_pkg::LUMA_W'(blue_o)  * rcr_pkg::LUMA_W'(rcr_pkg::LUMA_B);
    luma_o   = luma_sum[15:8];
  end

endmodule

FILE: rtl/rgb565_crop_rotate_to_rgb_luma_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_crop_rotate_to_rgb_luma_top: center crop, downscale and half turn
// Samples a centered square of an RGB565 raster by nearest neighbor and
// emits each sampled pixel as RGB888 plus luma at its rotated index.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake                 Payload
// -------  ---  ------------------------  ---------------------------------
// in       in   in_valid_i / in_ready_o   pixel_word_i, frame_start_i
// out      out  out_valid_o / out_ready_i pixel_index_o, red_o, green_o,
//                                         blue_o, luma_o
//
// One item per cycle while the output is not stalled; a sampled pixel passes
// through the input register, then the result register, to the output.
// Pixels outside the sampled grid are consumed and give no item.
// Reset clears the position to the top-left of a frame and empties the pipe.
// A stalled output holds its item; the input register keeps accepting while
// the result register has room, so ready drops only with both stages full.

module rgb565_crop_rotate_to_rgb_luma_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [rcr_pkg::PIX_W-1:0] pixel_word_i,
  input  logic                      frame_start_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rcr_pkg::IDX_W-1:0] pixel_index_o,
  output logic [rcr_pkg::CH_W-1:0]  red_o,
  output logic [rcr_pkg::CH_W-1:0]  green_o,
  output logic [rcr_pkg::CH_W-1:0]  blue_o,
  output logic [rcr_pkg::CH_W-1:0]  luma_o
);

  rcr_pkg::pos_sel_t          sel;
  logic                       in_acc, s1_adv;
  logic                       s1_valid_q, out_valid_q;
  logic [rcr_pkg::PIX_W-1:0]  s1_word_q;
  logic [rcr_pkg::IDX_W-1:0]  s1_index_q, out_index_q;
  logic [rcr_pkg::CH_W-1:0]   red_d, green_d, blue_d, luma_d;
  logic [rcr_pkg::CH_W-1:0]   red_q, green_q, blue_q, luma_q;

  // Handshake
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // Position tracking and sample select
  rcr_position u_position (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_acc),
    .frame_start_i (frame_start_i),
    .sel_o         (sel)
  );

  // Input register: only sampled pixels occupy it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_acc && sel.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      s1_word_q  <= pixel_word_i;
      s1_index_q <= sel.index;
    end
  end

  // Color expansion
  rcr_color u_color (
    .pixel_word_i (s1_word_q),
    .red_o        (red_d),
    .green_o      (green_d),
    .blue_o       (blue_d),
    .luma_o       (luma_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_index_q <= s1_index_q;
      red_q       <= red_d;
      green_q     <= green_d;
      blue_q      <= blue_d;
      luma_q      <= luma_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = out_index_q;
  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;
  assign luma_o        = luma_q;

`ifndef SYNTHESIS
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with room in the pipe");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_index_q)))
    else $error("stalled input-stage item lost");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a staged item");
`endif

endmodule

FILE: bench/crop_rotate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crop_rotate_checker: scoreboard for the crop/rotate color front end
// Follows every accepted pixel through its own copy of the crop, downscale
// and half-turn position tracking, queues the expected RGB888 and luma item
// and compares each item taken from the output channel against the oldest.
// ----------------------------------------------------------------------------
module crop_rotate_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [rcr_pkg::PIX_W-1:0] pixel_word_i,
  input  logic                      frame_start_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [rcr_pkg::IDX_W-1:0] pixel_index_i,
  input  logic [rcr_pkg::CH_W-1:0]  red_i,
  input  logic [rcr_pkg::CH_W-1:0]  green_i,
  input  logic [rcr_pkg::CH_W-1:0]  blue_i,
  input  logic [rcr_pkg::CH_W-1:0]  luma_i,
  output int                        mismatches_o,
  output int                        pending_o,
  output int                        pixels_o,
  output int                        results_o
);
  import rcr_pkg::*;

  localparam int MAX5     = 31;
  localparam int MAX6     = 63;
  localparam int MAX_SHOW = 40;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  luma;
  } rgb_luma_t;

  // expected output items, oldest first
  rgb_luma_t sampled_q[$];

  // position tracking
  logic [SCOL_W-1:0] src_col;
  logic [SROW_W-1:0] src_row;
  logic [OCOL_W-1:0] out_col;
  logic [OROW_W-1:0] out_row;
  logic [CTGT_W-1:0] col_target;
  logic [RTGT_W-1:0] row_target;

  int mismatches = 0;
  int pending    = 0;
  int pixels     = 0;
  int results    = 0;

  assign mismatches_o = mismatches;
  assign pending_o    = pending;
  assign pixels_o     = pixels;
  assign results_o    = results;

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_SHOW) begin
      $display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
    end
  endtask

  task automatic restart_position();
    src_col    = '0;
    src_row    = '0;
    out_col    = '0;
    out_row    = '0;
    col_target = CTGT_W'(CROP_ORIGIN);
    row_target = '0;
  endtask

  // advance the position by one source pixel, queue an item on a grid hit
  task automatic track_pixel(input logic [PIX_W-1:0] word, input logic start);
    logic      row_hit;
    int        r;
    int        g;
    int        b;
    int        idx;
    rgb_luma_t px;
    if (start) begin
      restart_position();
    end
    row_hit = (int'(out_row) < OUT_HEIGHT) && (src_row == row_target);
    if (row_hit && int'(out_col) < OUT_WIDTH && src_col == col_target) begin
      r   = (int'(word[15:11]) * 255) / MAX5;
      g   = (int'(word[10:5]) * 255) / MAX6;
      b   = (int'(word[4:0]) * 255) / MAX5;
      // half turn: first sampled pixel lands at the last index
      idx = (OUT_HEIGHT - 1 - int'(out_row)) * OUT_WIDTH
          + (OUT_WIDTH - 1 - int'(out_col));
      px.index = IDX_W'(idx);
      px.red   = CH_W'(r);
      px.green = CH_W'(g);
      px.blue  = CH_W'(b);
      px.luma  = CH_W'((LUMA_R * r + LUMA_G * g + LUMA_B * b) >> 8);
      sampled_q.push_back(px);
      out_col    = out_col + 1'b1;
      col_target = CTGT_W'(CROP_ORIGIN + (int'(out_col) * SRC_HEIGHT) / OUT_WIDTH);
    end
    // end of a source row; end of frame wraps as if a new frame started
    if (int'(src_col) + 1 >= SRC_WIDTH) begin
      src_col    = '0;
      out_col    = '0;
      col_target = CTGT_W'(CROP_ORIGIN);
      if (row_hit) begin
        out_row    = out_row + 1'b1;
        row_target = RTGT_W'((int'(out_row) * SRC_HEIGHT) / OUT_HEIGHT);
      end
      if (int'(src_row) + 1 >= SRC_HEIGHT) begin
        restart_position();
      end else begin
        src_row = src_row + 1'b1;
      end
    end else begin
      src_col = src_col + 1'b1;
    end
  endtask

  task automatic check_item();
    rgb_luma_t want;
    results++;
    if (sampled_q.size() == 0) begin
      report_mismatch("item with nothing pending, index", int'(pixel_index_i), -1);
    end else begin
      want = sampled_q.pop_front();
      if (pixel_index_i !== want.index) begin
        report_mismatch("pixel_index", int'(pixel_index_i), int'(want.index));
      end
      if (red_i !== want.red) begin
        report_mismatch("red", int'(red_i), int'(want.red));
      end
      if (green_i !== want.green) begin
        report_mismatch("green", int'(green_i), int'(want.green));
      end
      if (blue_i !== want.blue) begin
        report_mismatch("blue", int'(blue_i), int'(want.blue));
      end
      if (luma_i !== want.luma) begin
        report_mismatch("luma", int'(luma_i), int'(want.luma));
      end
    end
  endtask

  // watch both channels; new expectations go in before the oldest is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_position();
      sampled_q.delete();
      pixels  = 0;
      results = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        track_pixel(pixel_word_i, frame_start_i);
        pixels++;
      end
      if (out_valid_i && out_ready_i) begin
        check_item();
      end
    end
    pending = sampled_q.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the crop/rotate color front end
// Feeds color extremes and short random frames with stray frame starts, with
// random gaps on both channels and one long output hold-off; the scoreboard
// beside the block does the checking.
// ----------------------------------------------------------------------------
module tb;
  import rcr_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_mode_e;

  localparam int HOLD_OFF     = 300;
  localparam int RANDOM_ITEMS = 895;
  localparam int DRAIN        = 20;
  // allow about four times the slowest legal run
  localparam int LIMIT_NS     = 2_000_000;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  logic [PIX_W-1:0] pixel_word  = '0;
  logic             frame_start = 1'b0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  logic [IDX_W-1:0] pixel_index;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;
  logic [CH_W-1:0]  luma;

  int         mismatches;
  int         pending;
  int         pixels;
  int         results;
  idle_mode_e idle_mode    = IDLE_FULL;
  bit         hold_off_req = 1'b0;

  always #2 clk = ~clk;

  rgb565_crop_rotate_to_rgb_luma_top uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .pixel_word_i  (pixel_word),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_index_o (pixel_index),
    .red_o         (red),
    .green_o       (green),
    .blue_o        (blue),
    .luma_o        (luma)
  );

  crop_rotate_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .pixel_word_i  (pixel_word),
    .frame_start_i (frame_start),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_index_i (pixel_index),
    .red_i         (red),
    .green_i       (green),
    .blue_i        (blue),
    .luma_i        (luma),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .pixels_o      (pixels),
    .results_o     (results)
  );

  // gap length: mostly none or short, a few long
  function automatic int pick_gap(input idle_mode_e mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == IDLE_NONE) begin
      return 0;
    end
    if (mode == IDLE_LIGHT) begin
      return (r < 85) ? 0 : int'($urandom_range(1, 3));
    end
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // offer one item and hold it until taken
  task automatic send_pixel(input logic [PIX_W-1:0] word, input logic start);
    int gap;
    gap = pick_gap(idle_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_word  <= word;
    frame_start <= start;
    do @(posedge clk); while (!in_ready);
  endtask

  // output side: random ready runs and gaps, plus the requested hold-off
  initial begin : receiver
    int run;
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else begin
        run = $urandom_range(1, 24);
        out_ready <= 1'b1;
        repeat (run) @(posedge clk);
        gap = pick_gap(idle_mode);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int               sent;
    int               seg_left;
    int               r;
    logic [PIX_W-1:0] color_words [12] = '{
      16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'h8000,
      16'h0400, 16'h0010, 16'h0821, 16'h7BEF, 16'h8410, 16'hA5A5
    };

    // the first output hold-off is requested before the receiver starts
    idle_mode    = IDLE_NONE;
    hold_off_req = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // color extremes at the left edge of the crop, sent back to back while
    // the output is held off so the pipe fills and input stalls
    send_pixel(16'hFFFF, 1'b1);
    repeat (CROP_ORIGIN - 1) send_pixel(PIX_W'($urandom), 1'b0);
    foreach (color_words[i]) send_pixel(color_words[i], 1'b0);
    // frame start in mid row
    send_pixel(16'h1234, 1'b1);

    // random frames of random length with occasional stray frame starts
    sent     = 0;
    seg_left = 0;
    while (sent < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        r         = $urandom_range(0, 99);
        idle_mode = (r < 15) ? IDLE_NONE : (r < 45) ? IDLE_LIGHT : IDLE_FULL;
        seg_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(700, 1200)
                                                : $urandom_range(20, 700);
        send_pixel(PIX_W'($urandom), 1'b1);
      end else begin
        send_pixel(PIX_W'($urandom), $urandom_range(0, 99) < 2);
      end
      seg_left--;
      sent++;
    end
    in_valid <= 1'b0;

    // let the last items come out
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("run covered %0d pixels: color extremes, random frames with stray starts,",
             pixels);
    $display("row wraps and a stalled output; %0d output items compared", results);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("timeout with %0d items still expected", pending);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
